FILE: hdl/msc_pkg.sv
package msc_pkg;

  localparam int DW     = 32;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 67;

  localparam logic [1:0] OP_PROC = 2'd0;
  localparam logic [1:0] OP_MODE = 2'd1;
  localparam logic [1:0] OP_COLL = 2'd2;

  localparam logic [2:0] CFG_MODES  = 3'd0;
  localparam logic [2:0] CFG_COLLS  = 3'd1;
  localparam logic [2:0] CFG_THRESH = 3'd2;
  localparam logic [2:0] CFG_STIFF  = 3'd3;
  localparam logic [2:0] CFG_GAIN   = 3'd4;

  localparam logic [2:0] SEL_A1   = 3'd0;
  localparam logic [2:0] SEL_A2   = 3'd1;
  localparam logic [2:0] SEL_B1   = 3'd2;
  localparam logic [2:0] SEL_WIN  = 3'd3;
  localparam logic [2:0] SEL_WOUT = 3'd4;
  localparam logic [2:0] SEL_CIN  = 3'd0;
  localparam logic [2:0] SEL_COUT = 3'd1;

  // operand pair and destination of one multiply-accumulate step
  typedef enum logic [3:0] {
    SRC_FORCE = 4'd0,
    SRC_CIN   = 4'd1,
    SRC_WIN   = 4'd2,
    SRC_B1    = 4'd3,
    SRC_A1    = 4'd4,
    SRC_A2    = 4'd5,
    SRC_WOUT  = 4'd6,
    SRC_COUT  = 4'd7,
    SRC_GAIN  = 4'd8
  } src_e;

  typedef struct packed {
    logic start;
    logic load;
    src_e src;
    logic mul_en;
    logic acc_en;
    logic acc_sat;
    logic drv_latch;
    logic y_latch;
    logic disp_upd;
    logic out_load;
    logic clr_c;
    logic inc_c;
    logic inc_n;
  } cmd_t;

  typedef struct packed {
    logic nc_zero;
    logic nm_zero;
    logic c_last;
    logic n_last;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/msc_ram.sv
module msc_ram #(
  parameter int W = 32,
  parameter int D = 64,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

FILE: hdl/msc_dp.sv
module msc_dp #(
  parameter int MAX_MODES     = 64,
  parameter int MAX_COLLIDERS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [1:0]          opcode_i,
  input  logic [5:0]          mode_index_i,
  input  logic [2:0]          collider_index_i,
  input  logic [2:0]          coef_select_i,
  input  logic signed [31:0]  coef_value_i,
  input  logic signed [31:0]  sample_in_i,
  input  logic                last_in_block_i,
  output logic signed [31:0]  sample_out_o,
  output logic                last_out_o,
  input  msc_pkg::cmd_t       cmd_i,
  output msc_pkg::stat_t      stat_o
);
  import msc_pkg::*;

  localparam int MW = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int CW = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
  localparam int WD = MAX_MODES * MAX_COLLIDERS;
  localparam int WW = (WD > 1) ? $clog2(WD) : 1;

  // configuration
  logic [6:0]         am_q;
  logic [3:0]         ac_q;
  logic signed [28:0] thr_q;
  logic [28:0]        stf_q;
  logic signed [31:0] gain_q;

  logic [8:0] nm;
  logic [5:0] nc;
  logic [MW-1:0] n_q;
  logic [CW-1:0] c_q;

  logic [MAX_MODES-1:0] vld_q;
  logic signed [31:0] disp_q [MAX_COLLIDERS];
  logic signed [31:0] frc_q  [MAX_COLLIDERS];
  logic signed [ACC_W-1:0] cacc_q [MAX_COLLIDERS];

  logic signed [ACC_W-1:0] acc_q, pick_q;
  logic signed [31:0] x_q, drv_q, y_q, res_q, sout_q;
  logic lst_q, lout_q;

  logic signed [33:0] ma;
  logic signed [32:0] mb;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [63:0] p64, rnd;
  logic signed [ACC_W-1:0] term;
  logic signed [33:0] dlt;
  logic dpos;
  logic signed [31:0] y_new, pick_sat;

  logic mode_ok, coll_ok;
  logic [MW-1:0] m_waddr;
  logic [WW-1:0] w_waddr, w_raddr;
  logic mode_ld, coll_ld;

  logic [31:0] a1_rd, a2_rd, b1_rd, win_rd, wout_rd, cin_rd, cout_rd, p1_rd, p2_rd;
  logic signed [31:0] p1_val, p2_val;

  assign nm = (9'(am_q) > 9'(MAX_MODES)) ? 9'(MAX_MODES) : 9'(am_q);
  assign nc = (6'(ac_q) > 6'(MAX_COLLIDERS)) ? 6'(MAX_COLLIDERS) : 6'(ac_q);

  assign stat_o.nc_zero = (nc == 6'd0);
  assign stat_o.nm_zero = (nm == 9'd0);
  assign stat_o.c_last  = (6'(c_q) == nc - 6'd1);
  assign stat_o.n_last  = (9'(n_q) == nm - 9'd1);

  // coefficient loads
  assign mode_ok = 9'(mode_index_i) < 9'(MAX_MODES);
  assign coll_ok = mode_ok && (6'(collider_index_i) < 6'(MAX_COLLIDERS));
  assign mode_ld = cmd_i.load && (opcode_i == OP_MODE) && mode_ok;
  assign coll_ld = cmd_i.load && (opcode_i == OP_COLL) && coll_ok;
  assign m_waddr = MW'(mode_index_i);
  assign w_waddr = WW'(collider_index_i) * WW'(MAX_MODES) + WW'(mode_index_i);
  assign w_raddr = WW'(c_q) * WW'(MAX_MODES) + WW'(n_q);

  msc_ram #(.W(32), .D(MAX_MODES)) u_a1 (
    .clk_i, .we_i(mode_ld && coef_select_i == SEL_A1), .waddr_i(m_waddr),
    .wdata_i(coef_value_i), .raddr_i(n_q), .rdata_o(a1_rd));
  msc_ram #(.W(32), .D(MAX_MODES)) u_a2 (
    .clk_i, .we_i(mode_ld && coef_select_i == SEL_A2), .waddr_i(m_waddr),
    .wdata_i(coef_value_i), .raddr_i(n_q), .rdata_o(a2_rd));
  msc_ram #(.W(32), .D(MAX_MODES)) u_b1 (
    .clk_i, .we_i(mode_ld && coef_select_i == SEL_B1), .waddr_i(m_waddr),
    .wdata_i(coef_value_i), .raddr_i(n_q), .rdata_o(b1_rd));
  msc_ram #(.W(32), .D(MAX_MODES)) u_win (
    .clk_i, .we_i(mode_ld && coef_select_i == SEL_WIN), .waddr_i(m_waddr),
    .wdata_i(coef_value_i), .raddr_i(n_q), .rdata_o(win_rd));
  msc_ram #(.W(32), .D(MAX_MODES)) u_wout (
    .clk_i, .we_i(mode_ld && coef_select_i == SEL_WOUT), .waddr_i(m_waddr),
    .wdata_i(coef_value_i), .raddr_i(n_q), .rdata_o(wout_rd));
  msc_ram #(.W(32), .D(WD)) u_cin (
    .clk_i, .we_i(coll_ld && coef_select_i == SEL_CIN), .waddr_i(w_waddr),
    .wdata_i(coef_value_i), .raddr_i(w_raddr), .rdata_o(cin_rd));
  msc_ram #(.W(32), .D(WD)) u_cout (
    .clk_i, .we_i(coll_ld && coef_select_i == SEL_COUT), .waddr_i(w_waddr),
    .wdata_i(coef_value_i), .raddr_i(w_raddr), .rdata_o(cout_rd));

  // resonator history; an entry never written reads as zero
  assign p1_val = vld_q[n_q] ? signed'(p1_rd) : 32'sd0;
  assign p2_val = vld_q[n_q] ? signed'(p2_rd) : 32'sd0;
  assign y_new  = sat32(64'(acc_q));

  msc_ram #(.W(32), .D(MAX_MODES)) u_p1 (
    .clk_i, .we_i(cmd_i.y_latch), .waddr_i(n_q), .wdata_i(y_new),
    .raddr_i(n_q), .rdata_o(p1_rd));
  msc_ram #(.W(32), .D(MAX_MODES)) u_p2 (
    .clk_i, .we_i(cmd_i.y_latch), .waddr_i(n_q), .wdata_i(p1_val),
    .raddr_i(n_q), .rdata_o(p2_rd));

  // penetration depth below the threshold
  assign dlt  = {{5{thr_q[28]}}, thr_q} - {{2{disp_q[c_q][31]}}, disp_q[c_q]};
  assign dpos = !dlt[33] && (dlt != 34'sd0);
  assign pick_sat = sat32(64'(pick_q));

  always_comb begin
    ma = 34'sd0;
    mb = 33'sd0;
    case (cmd_i.src)
      SRC_FORCE: begin ma = dlt;                          mb = {4'b0, stf_q}; end
      SRC_CIN:   begin ma = {{2{cin_rd[31]}}, cin_rd};    mb = {frc_q[c_q][31], frc_q[c_q]}; end
      SRC_WIN:   begin ma = {{2{win_rd[31]}}, win_rd};    mb = {x_q[31], x_q}; end
      SRC_B1:    begin ma = {{2{b1_rd[31]}}, b1_rd};      mb = {drv_q[31], drv_q}; end
      SRC_A1:    begin ma = {{2{a1_rd[31]}}, a1_rd};      mb = {p1_val[31], p1_val}; end
      SRC_A2:    begin ma = {{2{a2_rd[31]}}, a2_rd};      mb = {p2_val[31], p2_val}; end
      SRC_WOUT:  begin ma = {{2{y_q[31]}}, y_q};          mb = {wout_rd[31], wout_rd}; end
      SRC_COUT:  begin ma = {{2{y_q[31]}}, y_q};          mb = {cout_rd[31], cout_rd}; end
      SRC_GAIN:  begin ma = {{2{pick_sat[31]}}, pick_sat}; mb = {gain_q[31], gain_q}; end
      default:   begin ma = 34'sd0;                       mb = 33'sd0; end
    endcase
  end

  // round half up: force is Q20.12 scaled, everything else Q8.24
  assign p64  = prod_q[63:0];
  assign rnd  = (cmd_i.src == SRC_FORCE) ? ((p64 + 64'sd2048) >>> 12)
                                         : ((p64 + 64'sd8388608) >>> 24);
  assign term = rnd[ACC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      am_q   <= '0;
      ac_q   <= '0;
      thr_q  <= -29'sd16777;
      stf_q  <= '0;
      gain_q <= 32'sd16777216;
      n_q    <= '0;
      c_q    <= '0;
      vld_q  <= '0;
      for (int i = 0; i < MAX_COLLIDERS; i++) begin
        disp_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODES:  am_q   <= cfg_data_i[6:0];
          CFG_COLLS:  ac_q   <= cfg_data_i[3:0];
          CFG_THRESH: thr_q  <= cfg_data_i[28:0];
          CFG_STIFF:  stf_q  <= cfg_data_i[28:0];
          CFG_GAIN:   gain_q <= cfg_data_i;
          default:    ;
        endcase
      end
      if (cmd_i.start) begin
        n_q <= '0;
        c_q <= '0;
      end
      if (cmd_i.clr_c) begin
        c_q <= '0;
      end
      if (cmd_i.inc_c) begin
        c_q <= c_q + CW'(1);
      end
      if (cmd_i.inc_n) begin
        n_q <= n_q + MW'(1);
      end
      if (cmd_i.y_latch) begin
        vld_q[n_q] <= 1'b1;
      end
      if (cmd_i.disp_upd) begin
        for (int i = 0; i < MAX_COLLIDERS; i++) begin
          disp_q[i] <= sat32(64'(cacc_q[i]));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ma * mb;
    end
    if (cmd_i.start) begin
      x_q    <= sample_in_i;
      lst_q  <= last_in_block_i;
      acc_q  <= '0;
      pick_q <= '0;
      for (int i = 0; i < MAX_COLLIDERS; i++) begin
        cacc_q[i] <= '0;
      end
    end
    if (cmd_i.acc_sat) begin
      acc_q <= ACC_W'(sat32(64'(acc_q)));
    end
    if (cmd_i.drv_latch) begin
      drv_q <= sat32(64'(acc_q));
      acc_q <= '0;
    end
    if (cmd_i.y_latch) begin
      y_q   <= y_new;
      acc_q <= '0;
    end
    if (cmd_i.acc_en) begin
      case (cmd_i.src)
        SRC_FORCE: frc_q[c_q] <= dpos ? sat32(rnd) : 32'sd0;
        SRC_CIN, SRC_WIN, SRC_B1, SRC_A1, SRC_A2: acc_q <= acc_q + term;
        SRC_WOUT:  pick_q <= pick_q + term;
        SRC_COUT:  cacc_q[c_q] <= cacc_q[c_q] + term;
        SRC_GAIN:  res_q <= sat32(rnd);
        default:   ;
      endcase
    end
    if (cmd_i.out_load) begin
      sout_q <= res_q;
      lout_q <= lst_q;
    end
  end

  assign sample_out_o = sout_q;
  assign last_out_o   = lout_q;

endmodule

FILE: hdl/msc_ctrl.sv
module msc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     opcode_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  msc_pkg::stat_t stat_i,
  output msc_pkg::cmd_t  cmd_o
);
  import msc_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_FORCE = 15'b000000000000010,
    S_MCIN  = 15'b000000000000100,
    S_MSAT  = 15'b000000000001000,
    S_MWIN  = 15'b000000000010000,
    S_MDRV  = 15'b000000000100000,
    S_MB1   = 15'b000000001000000,
    S_MA1   = 15'b000000010000000,
    S_MA2   = 15'b000000100000000,
    S_MY    = 15'b000001000000000,
    S_MWOUT = 15'b000010000000000,
    S_MCOUT = 15'b000100000000000,
    S_UPD   = 15'b001000000000000,
    S_GAIN  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  localparam logic [1:0] PH_MUL = 2'd1;
  localparam logic [1:0] PH_ACC = 2'd2;

  state_e state_q, state_d;
  logic [1:0] ph_q, ph_d;
  logic ovalid_q, ovalid_d;
  logic mac, done;
  state_e first_mode;

  assign first_mode = stat_i.nc_zero ? S_MSAT : S_MCIN;
  assign done       = (ph_q == PH_ACC);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    mac     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_PROC) begin
            cmd_o.start = 1'b1;
            if (!stat_i.nc_zero) begin
              state_d = S_FORCE;
            end else if (stat_i.nm_zero) begin
              state_d = S_UPD;
            end else begin
              state_d = S_MSAT;
            end
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_FORCE: begin
        mac = 1'b1;
        cmd_o.src = SRC_FORCE;
        if (done) begin
          if (!stat_i.c_last) begin
            cmd_o.inc_c = 1'b1;
          end else begin
            cmd_o.clr_c = 1'b1;
            state_d = stat_i.nm_zero ? S_UPD : S_MCIN;
          end
        end
      end
      S_MCIN: begin
        mac = 1'b1;
        cmd_o.src = SRC_CIN;
        if (done) begin
          if (!stat_i.c_last) begin
            cmd_o.inc_c = 1'b1;
          end else begin
            cmd_o.clr_c = 1'b1;
            state_d = S_MSAT;
          end
        end
      end
      S_MSAT: begin
        cmd_o.acc_sat = 1'b1;
        state_d = S_MWIN;
      end
      S_MWIN: begin
        mac = 1'b1;
        cmd_o.src = SRC_WIN;
        if (done) state_d = S_MDRV;
      end
      S_MDRV: begin
        cmd_o.drv_latch = 1'b1;
        state_d = S_MB1;
      end
      S_MB1: begin
        mac = 1'b1;
        cmd_o.src = SRC_B1;
        if (done) state_d = S_MA1;
      end
      S_MA1: begin
        mac = 1'b1;
        cmd_o.src = SRC_A1;
        if (done) state_d = S_MA2;
      end
      S_MA2: begin
        mac = 1'b1;
        cmd_o.src = SRC_A2;
        if (done) state_d = S_MY;
      end
      S_MY: begin
        cmd_o.y_latch = 1'b1;
        state_d = S_MWOUT;
      end
      S_MWOUT: begin
        mac = 1'b1;
        cmd_o.src = SRC_WOUT;
        if (done) begin
          if (!stat_i.nc_zero) begin
            state_d = S_MCOUT;
          end else if (stat_i.n_last) begin
            state_d = S_UPD;
          end else begin
            cmd_o.inc_n = 1'b1;
            state_d = first_mode;
          end
        end
      end
      S_MCOUT: begin
        mac = 1'b1;
        cmd_o.src = SRC_COUT;
        if (done) begin
          if (!stat_i.c_last) begin
            cmd_o.inc_c = 1'b1;
          end else begin
            cmd_o.clr_c = 1'b1;
            if (stat_i.n_last) begin
              state_d = S_UPD;
            end else begin
              cmd_o.inc_n = 1'b1;
              state_d = first_mode;
            end
          end
        end
      end
      S_UPD: begin
        cmd_o.disp_upd = 1'b1;
        state_d = S_GAIN;
      end
      S_GAIN: begin
        mac = 1'b1;
        cmd_o.src = SRC_GAIN;
        if (done) state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // address settles, then multiply, then accumulate
    cmd_o.mul_en = mac && (ph_q == PH_MUL);
    cmd_o.acc_en = mac && done;
    ph_d = (mac && !done) ? ph_q + 2'd1 : 2'd0;

    if (cmd_o.out_load) begin
      ovalid_d = 1'b1;
    end else if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ph_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      ovalid_q <= ovalid_d;
    end
  end

`ifndef SYNTHESIS
  a_mul_then_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_en |=> cmd_o.acc_en)
    else $error("product not accumulated in the following cycle");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while held");

  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && opcode_i == OP_PROC) |=> in_stall_o)
    else $error("sample beat not followed by busy");
`endif

endmodule

FILE: hdl/modal_string_collision_synth.sv
// One item at a time. A load beat (opcodes 1 to 3) is taken while the block stays idle.
// A sample beat works through every active collider and mode before its result is offered;
// every multiply runs through one shared multiplier as read, multiply and accumulate steps.
// The result waits in an output register; the next beat is taken while it waits.
// Reset: configuration to defaults, resonator history and colliders zero; coefficients undefined.
module modal_string_collision_synth #(
  parameter int MAX_MODES     = 64,
  parameter int MAX_COLLIDERS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [5:0]         mode_index_i,
  input  logic [2:0]         collider_index_i,
  input  logic [2:0]         coef_select_i,
  input  logic signed [31:0] coef_value_i,
  input  logic signed [31:0] sample_in_i,
  input  logic               last_in_block_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] sample_out_o,
  output logic               last_out_o
);
  import msc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  msc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .opcode_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  msc_dp #(
    .MAX_MODES     (MAX_MODES),
    .MAX_COLLIDERS (MAX_COLLIDERS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .opcode_i,
    .mode_index_i,
    .collider_index_i,
    .coef_select_i,
    .coef_value_i,
    .sample_in_i,
    .last_in_block_i,
    .sample_out_o,
    .last_out_o,
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

FILE: verif/tb.sv
module tb;
  import msc_pkg::*;

  localparam int NMODES = 64;
  localparam int NCOLL  = 8;
  localparam int LIMIT  = 3_000_000;
  localparam int ITEMS  = 180;

  typedef struct {
    logic [31:0] smp;
    logic        lst;
  } synth_out_t;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  mi;
    logic [2:0]  ci;
    logic [2:0]  sel;
    logic [31:0] val;
    logic [31:0] x;
    logic        last;
    bit          typed;
    logic [31:0] smp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [5:0] mode_index = '0;
  logic [2:0] collider_index = '0;
  logic [2:0] coef_select = '0;
  logic signed [31:0] coef_value = '0;
  logic signed [31:0] sample_in = '0;
  logic last_in_block = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] sample_out;
  logic last_out;

  modal_string_collision_synth DUT (
    .clk_i(clk), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .mode_index_i(mode_index), .collider_index_i(collider_index),
    .coef_select_i(coef_select), .coef_value_i(coef_value), .sample_in_i(sample_in),
    .last_in_block_i(last_in_block),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sample_out_o(sample_out), .last_out_o(last_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // synth state mirror
  int unsigned r_modes = 0, r_colls = 0;
  longint r_thresh = -16777, r_stiff = 0, r_gain = 16777216;
  int mprev1[NMODES], mprev2[NMODES], cdisp[NCOLL];
  int fb1[NMODES], fb2[NMODES], drv[NMODES], win[NMODES], wout[NMODES];
  int cin[NMODES*NCOLL], cout[NMODES*NCOLL];
  bit [4:0] mode_set[NMODES];
  bit [1:0] coll_set[NMODES*NCOLL];

  synth_out_t expected_samples[$];
  synth_out_t head;
  int errors = 0;
  int counted = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  function automatic longint rnd_shift(longint p, int s);
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qprod(longint a, longint b);
    return rnd_shift(a * b, 24);
  endfunction

  task automatic apply_beat(input logic [1:0] op, input logic [5:0] mi, input logic [2:0] ci,
                            input logic [2:0] sel, input logic [31:0] val,
                            input logic [31:0] x, input logic last,
                            output bit produced, output synth_out_t res);
    int nm, nc, k;
    longint frc[NCOLL], cacc[NCOLL];
    longint pick, fsum, drive, y, xs;
    produced = 0;
    k = int'(ci) * NMODES + int'(mi);
    if (op == OP_MODE) begin
      case (sel)
        SEL_A1:   begin fb1[mi]  = val; mode_set[mi][0] = 1; end
        SEL_A2:   begin fb2[mi]  = val; mode_set[mi][1] = 1; end
        SEL_B1:   begin drv[mi]  = val; mode_set[mi][2] = 1; end
        SEL_WIN:  begin win[mi]  = val; mode_set[mi][3] = 1; end
        SEL_WOUT: begin wout[mi] = val; mode_set[mi][4] = 1; end
        default: ;
      endcase
    end else if (op == OP_COLL) begin
      if (sel == SEL_CIN) begin
        cin[k] = val; coll_set[k][0] = 1;
      end else if (sel == SEL_COUT) begin
        cout[k] = val; coll_set[k][1] = 1;
      end
    end else if (op == OP_PROC) begin
      xs = longint'($signed(x));
      nm = (r_modes > NMODES) ? NMODES : r_modes;
      nc = (r_colls > NCOLL) ? NCOLL : r_colls;
      pick = 0;
      for (int c = 0; c < NCOLL; c++) begin
        frc[c] = 0;
        cacc[c] = 0;
      end
      for (int c = 0; c < nc; c++) begin
        if (r_thresh - cdisp[c] > 0)
          frc[c] = clip32(rnd_shift((r_thresh - cdisp[c]) * r_stiff, 12));
      end
      for (int c = 0; c < NCOLL; c++) cdisp[c] = 0;
      for (int n = 0; n < nm; n++) begin
        fsum = 0;
        for (int c = 0; c < nc; c++) fsum += qprod(cin[c*NMODES+n], frc[c]);
        drive = clip32(qprod(win[n], xs) + clip32(fsum));
        y = clip32(qprod(drv[n], drive) + qprod(fb1[n], mprev1[n]) + qprod(fb2[n], mprev2[n]));
        mprev2[n] = mprev1[n];
        mprev1[n] = int'(y);
        pick += qprod(y, wout[n]);
        for (int c = 0; c < nc; c++) cacc[c] += qprod(y, cout[c*NMODES+n]);
      end
      for (int c = 0; c < nc; c++) cdisp[c] = int'(clip32(cacc[c]));
      res.smp = 32'(clip32(qprod(clip32(pick), r_gain)));
      res.lst = last;
      produced = 1;
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("tb: mismatch %s got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic send(input logic [1:0] op, input logic [5:0] mi, input logic [2:0] ci,
                      input logic [2:0] sel, input logic [31:0] val, input logic [31:0] x,
                      input logic last, input bit typed, input logic [31:0] typed_smp);
    bit got;
    synth_out_t r;
    if (!quiet && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
      repeat ($urandom_range(3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    mode_index <= mi;
    collider_index <= ci;
    coef_select <= sel;
    coef_value <= val;
    sample_in <= x;
    last_in_block <= last;
    do @(posedge clk); while (in_stall);
    apply_beat(op, mi, ci, sel, val, x, last, got, r);
    if (got) begin
      if (typed) r.smp = typed_smp;
      expected_samples.push_back(r);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    logic [28:0] t;
    t = data[28:0];
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODES:  r_modes = data & 32'h7f;
      CFG_COLLS:  r_colls = data & 32'hf;
      CFG_THRESH: r_thresh = longint'($signed(t));
      CFG_STIFF:  r_stiff = longint'(data & 32'h1fffffff);
      CFG_GAIN:   r_gain = longint'($signed(data));
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_coef();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 32'($signed($urandom_range(32'h00ffffff)) - 32'sh00800000);
    if (r < 85) return 32'($signed($urandom_range(32'h03ffffff)) - 32'sh02000000);
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h7fffffff;
    if (r == 1) return 32'h80000000;
    if (r < 5) return $urandom;
    return 32'($signed($urandom_range(32'h01ffffff)) - 32'sh01000000);
  endfunction

  // every coefficient a sample will touch must be loaded first
  task automatic load_missing();
    int nm, nc;
    nm = (r_modes > NMODES) ? NMODES : r_modes;
    nc = (r_colls > NCOLL) ? NCOLL : r_colls;
    for (int n = 0; n < nm; n++)
      for (int s = 0; s < 5; s++)
        if (!mode_set[n][s])
          send(OP_MODE, 6'(n), 3'($urandom), 3'(s), rand_coef(), $urandom, $urandom, 0, '0);
    for (int c = 0; c < nc; c++)
      for (int n = 0; n < nm; n++)
        for (int s = 0; s < 2; s++)
          if (!coll_set[c*NMODES+n][s])
            send(OP_COLL, 6'(n), 3'(c), 3'(s), rand_coef(), $urandom, $urandom, 0, '0);
  endtask

  task automatic random_beat();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      send(OP_PROC, 6'($urandom), 3'($urandom), 3'($urandom), $urandom, rand_sample(),
           $urandom, 0, '0);
      counted++;
    end else if (r < 86) begin
      send(OP_MODE, 6'($urandom), 3'($urandom), 3'($urandom_range(4)), rand_coef(), $urandom,
           $urandom, 0, '0);
      counted++;
    end else if (r < 94) begin
      send(OP_COLL, 6'($urandom), 3'($urandom), 3'($urandom_range(1)), rand_coef(), $urandom,
           $urandom, 0, '0);
      counted++;
    end else if (r < 97) begin
      send(2'd3, 6'($urandom), 3'($urandom), 3'($urandom), $urandom, $urandom, $urandom, 0, '0);
    end else if (r < 99) begin
      send(OP_MODE, 6'($urandom), 3'($urandom), 3'($urandom_range(7, 5)), $urandom, $urandom,
           $urandom, 0, '0);
    end else begin
      send(OP_COLL, 6'($urandom), 3'($urandom), 3'($urandom_range(7, 2)), $urandom, $urandom,
           $urandom, 0, '0);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= !quiet && ($urandom_range(99) < 31);

  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report("unexpected beat", sample_out, '0);
      end else begin
        head = expected_samples.pop_front();
        if (sample_out !== head.smp) report("sample_out", sample_out, head.smp);
        if (last_out !== head.lst) report("last_out", 32'(last_out), 32'(head.lst));
      end
    end
  end

  stim_row_t directed[$];
  logic [31:0] cfg_sets[$][5];
  logic [31:0] cfgv[5];

  initial begin
    // reset config: zero modes, so every sample comes out zero
    directed = '{
      '{OP_PROC, 6'd63, 3'd7, 3'd7, 32'hffffffff, 32'h7fffffff, 1'b1, 1'b1, 32'h0},
      '{OP_PROC, 6'd0,  3'd0, 3'd0, 32'h0,        32'h80000000, 1'b0, 1'b1, 32'h0},
      '{2'd3,    6'd63, 3'd7, 3'd7, 32'hffffffff, 32'hffffffff, 1'b1, 1'b0, 32'h0},
      '{OP_MODE, 6'd63, 3'd0, 3'd7, 32'hffffffff, 32'h0,        1'b0, 1'b0, 32'h0},
      '{OP_COLL, 6'd63, 3'd7, 3'd5, 32'hffffffff, 32'h0,        1'b0, 1'b0, 32'h0},
      '{OP_MODE, 6'd0,  3'd0, SEL_A1,   32'h7fffffff, 32'h0, 1'b0, 1'b0, 32'h0},
      '{OP_MODE, 6'd0,  3'd0, SEL_A2,   32'h80000000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{OP_MODE, 6'd0,  3'd0, SEL_B1,   32'h01000000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{OP_MODE, 6'd0,  3'd0, SEL_WIN,  32'h00800000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{OP_MODE, 6'd0,  3'd0, SEL_WOUT, 32'h01000000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{OP_COLL, 6'd0,  3'd0, SEL_CIN,  32'h00400000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{OP_COLL, 6'd0,  3'd0, SEL_COUT, 32'h80000000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{OP_PROC, 6'd0,  3'd0, 3'd0, 32'h0,        32'h00000000, 1'b1, 1'b1, 32'h0}
    };
    // modes, colliders, threshold, stiffness, gain
    cfg_sets.push_back('{32'd1,   32'd1,  -32'sd168,       32'd409600000, 32'h01000000});
    cfg_sets.push_back('{32'd2,   32'd1,  -32'sd167772160, 32'd0,         32'h7fffffff});
    cfg_sets.push_back('{32'd0,   32'd3,  -32'sd16777,     32'd4096000,   32'h01000000});
    cfg_sets.push_back('{32'd4,   32'd2,  -32'sd16777,     32'd4096000,   32'h80000000});
    cfg_sets.push_back('{32'd4,   32'd8,  -32'sd168,       32'd409600000, 32'h01000000});
    cfg_sets.push_back('{32'd3,   32'd15, -32'sd1677721,   32'd40960000,  32'h0});

    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send(directed[i].op, directed[i].mi, directed[i].ci, directed[i].sel, directed[i].val,
           directed[i].x, directed[i].last, directed[i].typed, directed[i].smp);

    for (int p = 0; p < 60 && counted < ITEMS; p++) begin
      if (p < cfg_sets.size()) begin
        cfgv = cfg_sets[p];
      end else begin
        cfgv[0] = $urandom_range(6, 1);
        cfgv[1] = $urandom_range(3);
        cfgv[2] = -$urandom_range(167772160, 168);
        cfgv[3] = $urandom_range(409600000);
        cfgv[4] = ($urandom_range(3) == 0) ? $urandom : rand_coef() + 32'h01000000;
      end
      drain();
      cfg_write(CFG_MODES, cfgv[0]);
      cfg_write(CFG_COLLS, cfgv[1]);
      cfg_write(CFG_THRESH, cfgv[2]);
      cfg_write(CFG_STIFF, cfgv[3]);
      cfg_write(CFG_GAIN, cfgv[4]);
      load_missing();
      for (int i = 0; i < ((cfgv[0] > 16) ? 5 : 30); i++) begin
        quiet = (counted >= 120 && counted < 180);
        random_beat();
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/msc_pkg.sv
hdl/msc_ram.sv
hdl/msc_dp.sv
hdl/msc_ctrl.sv
hdl/modal_string_collision_synth.sv
verif/tb.sv
